[src/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_EQ  = 3'd4;
    localparam logic [2:0] MODE_LT  = 3'd5;
    localparam logic [2:0] MODE_GT  = 3'd6;
    localparam logic [2:0] MODE_NOP = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Command and response between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_rsp_t;

endpackage

[src/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: sequencer around one shared 64-bit divider.
// Comparisons, errors and mode 7 go from S_MUL1 straight to the result; a zero numerator
// goes there from S_FORM; else the Euclidean GCD runs on the divider, then two divisions.
// One item at a time: s_tready is low from acceptance until the result transfer.
// The shift-subtract divider sets the rate.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, no result pending.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // a_num, a_den, b_num, b_den from bit 0
    input  logic [2:0]    s_tuser,  // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,  // res_num, res_den, then zero fill
    output logic [2:0]    m_tuser   // compare_true, status
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam logic [63:0] LIM = 64'd1 << (W - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_FORM  = 9'b000001000,
        S_GCD   = 9'b000010000,
        S_DIVN  = 9'b000100000,
        S_DIVD  = 9'b001000000,
        S_CHECK = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic        wait_reg, wait_next;
    logic [2:0]  mode_reg;
    logic signed [32:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [63:0] m1_reg, m2_reg, nm_reg, dm_reg, gx_reg, gy_reg;
    logic        s1_reg, s2_reg, nneg_reg, dneg_reg;
    logic [31:0] rnum_reg;
    logic [30:0] rden_reg;
    logic        cmp_reg;
    logic [1:0]  st_reg;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // Sign-extend an operand from its low W bits.
    function automatic logic signed [32:0] sx(input logic [31:0] v);
        logic [31:0] t;
        t = v << (32 - W);
        return 33'(signed'(t) >>> (32 - W));
    endfunction

    function automatic logic [31:0] mag(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v[32] ? -v : v;
        return t[31:0];
    endfunction

    rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, rden_reg, rnum_reg};
    assign m_tuser  = {st_reg, cmp_reg};

    // Sequencer: the products in S_MUL1 and S_MUL2, then the shared divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    logic signed [32:0] pa, pb, qa, qb;
    logic signed [65:0] lx, rx;
    logic               nneg_w;
    logic [63:0]        nm_w;
    logic [63:0]        q_w;

    always_comb
    begin
        pa = ad_reg[32] ? -an_reg : an_reg;
        pb = bd_reg[32] ? -bn_reg : bn_reg;
        qa = ad_reg[32] ? -ad_reg : ad_reg;
        qb = bd_reg[32] ? -bd_reg : bd_reg;
        lx = 66'(pa) * 66'(qb);
        rx = 66'(pb) * 66'(qa);
        if (s1_reg == s2_reg)
        begin
            nm_w = m1_reg + m2_reg;
            nneg_w = s1_reg;
        end
        else if (m1_reg >= m2_reg)
        begin
            nm_w = m1_reg - m2_reg;
            nneg_w = s1_reg;
        end
        else
        begin
            nm_w = m2_reg - m1_reg;
            nneg_w = s2_reg;
        end
        q_w = drsp.quotient;
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = 1'b0;
        dreq.start = 1'b0;
        dreq.dividend = gx_reg;
        dreq.divisor  = gy_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_MUL1;
            S_MUL1:
            begin
                if (mode_reg == MODE_NOP || ad_reg == 0 || bd_reg == 0 ||
                    (mode_reg == MODE_DIV && bn_reg == 0) || mode_reg[2])
                    state_next = S_OUT;
                else
                    state_next = S_MUL2;
            end
            S_MUL2:  state_next = S_FORM;
            S_FORM:  state_next = (nm_w == 64'd0) ? S_OUT : S_GCD;
            S_GCD:
            begin
                if (!wait_reg)
                begin
                    if (gy_reg == 64'd0)
                    begin
                        state_next = S_DIVN;
                        dreq.start = 1'b1;
                        dreq.dividend = nm_reg;
                        dreq.divisor  = gx_reg;
                        wait_next = 1'b1;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else
                    wait_next = !drsp.done;
            end
            S_DIVN:
            begin
                wait_next = !drsp.done;
                if (drsp.done)
                begin
                    state_next = S_DIVD;
                    dreq.start = 1'b1;
                    dreq.dividend = dm_reg;
                    dreq.divisor  = gx_reg;
                    wait_next = 1'b1;
                end
            end
            S_DIVD:
            begin
                wait_next = !drsp.done;
                if (drsp.done) state_next = S_CHECK;
            end
            S_CHECK: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg <= s_tuser;
                an_reg <= sx(s_tdata[31:0]);
                ad_reg <= sx(s_tdata[63:32]);
                bn_reg <= sx(s_tdata[95:64]);
                bd_reg <= sx(s_tdata[127:96]);
                rnum_reg <= '0;
                rden_reg <= 31'd1;
                cmp_reg <= 1'b0;
                st_reg <= ST_OK;
            end
            S_MUL1:
            begin
                if (mode_reg == MODE_NOP)
                    st_reg <= ST_OK;
                else if (ad_reg == 0 || bd_reg == 0 ||
                         (mode_reg == MODE_DIV && bn_reg == 0))
                    st_reg <= ST_ZERO;
                else if (mode_reg == MODE_EQ)
                    cmp_reg <= (lx == rx);
                else if (mode_reg == MODE_LT)
                    cmp_reg <= (lx < rx);
                else if (mode_reg == MODE_GT)
                    cmp_reg <= (lx > rx);
                // First product: numerator-side term.
                if (mode_reg == MODE_MUL)
                begin
                    m1_reg <= mag(an_reg) * mag(bn_reg);
                    s1_reg <= an_reg[32] ^ bn_reg[32];
                end
                else
                begin
                    m1_reg <= mag(an_reg) * mag(bd_reg);
                    s1_reg <= an_reg[32] ^ bd_reg[32];
                end
                m2_reg <= 64'd0;
                s2_reg <= s1_reg;
            end
            S_MUL2:
            begin
                if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
                begin
                    m2_reg <= mag(bn_reg) * mag(ad_reg);
                    s2_reg <= (bn_reg[32] ^ ad_reg[32]) ^ (mode_reg == MODE_SUB);
                end
                else
                begin
                    m2_reg <= 64'd0;
                    s2_reg <= s1_reg;
                end
                if (mode_reg == MODE_DIV)
                begin
                    dm_reg <= mag(ad_reg) * mag(bn_reg);
                    dneg_reg <= ad_reg[32] ^ bn_reg[32];
                end
                else
                begin
                    dm_reg <= mag(ad_reg) * mag(bd_reg);
                    dneg_reg <= ad_reg[32] ^ bd_reg[32];
                end
            end
            S_FORM:
            begin
                nm_reg <= nm_w;
                nneg_reg <= nneg_w;
                gx_reg <= nm_w;
                gy_reg <= dm_reg;
            end
            S_GCD:
            begin
                if (wait_reg && drsp.done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= drsp.remainder;
                end
            end
            S_DIVN:  if (drsp.done) nm_reg <= q_w;
            S_DIVD:  if (drsp.done) dm_reg <= q_w;
            S_CHECK:
            begin
                if (dm_reg > LIM - 64'd1 ||
                    ((nneg_reg ^ dneg_reg) ? nm_reg > LIM : nm_reg > LIM - 64'd1))
                    st_reg <= ST_OVF;
                else
                begin
                    rnum_reg <= (nneg_reg ^ dneg_reg) ? -nm_reg[31:0] : nm_reg[31:0];
                    rden_reg <= dm_reg[30:0];
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result only appears while no input is taken.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready and valid together");
    // A zero-denominator or overflow status always carries 0/1.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st_reg != ST_OK) |-> (rnum_reg == 32'd0 && rden_reg == 31'd1))
        else $error("error result not 0/1");
    // A finished result holds until the transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
`endif

endmodule

[src/rau_divider.sv]
// Shared restoring divider: one quotient bit per cycle over 64 bits.
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // Shift in one dividend bit and try the subtraction.
    always_comb
    begin
        shifted   = {rem_reg[63:0], quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[63:0];

endmodule
